// ===== src/ukst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unordered key set table package
// Shared constants, command codes, sequencer states and transfer structs.
// ----------------------------------------------------------------------------
package ukst_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned KeyW       = 32;
  localparam int unsigned SlotW      = 4;
  localparam int unsigned EntriesW   = 5;

  typedef enum logic [1:0] {
    CmdAdd    = 2'd0,
    CmdErase  = 2'd1,
    CmdPop    = 2'd2,
    CmdLookup = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StMove,
    StPop
  } state_e;

  typedef struct packed {
    cmd_e            command;
    logic [KeyW-1:0] key;
  } req_t;

  typedef struct packed {
    logic [SlotW-1:0]    slot;
    logic                found;
    logic                overflow;
    logic [KeyW-1:0]     popped_key;
    logic [EntriesW-1:0] entries;
  } rsp_t;

endpackage

// ===== src/unordered_key_set_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unordered key set table
// Dense set of distinct keys with add, swap-remove erase, pop and lookup.
// ----------------------------------------------------------------------------
// A pop reads the last slot and strobes its key from the pop state, and a pop on
//   an empty table strobes straight from idle; a search strobes on a hit or a miss
//   past the last entry, and an erase hit first moves the last key into the hit slot.
// One comparator walks the key RAM one slot per cycle through its registered
//   read port; busy stays high for the whole walk, so a new transfer is taken only
//   once the previous one is back in idle. Results cannot be stalled.
// Reset clears the state, entry count, indices and strobe; key RAM contents are left as they are.
module unordered_key_set_table_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ukst_pkg::req_t req_i,
  output logic          valid_o,
  output ukst_pkg::rsp_t rsp_o
);

  ukst_pkg::state_e state_q, state_d;
  ukst_pkg::cmd_e   cmd_q, cmd_d;
  logic [ukst_pkg::KeyW-1:0] key_q, key_d;
  logic [ukst_pkg::CntW-1:0] count_q, count_d;
  logic [ukst_pkg::CntW-1:0] ridx_q, ridx_d;
  logic [ukst_pkg::IdxW-1:0] cidx_q, cidx_d;
  logic pend_q, pend_d;
  logic valid_q, valid_d;
  ukst_pkg::rsp_t res_q, res_d;

  logic                      ram_we;
  logic [ukst_pkg::IdxW-1:0] ram_waddr;
  logic [ukst_pkg::KeyW-1:0] ram_wdata;
  logic [ukst_pkg::IdxW-1:0] ram_raddr;
  logic [ukst_pkg::KeyW-1:0] ram_rdata;

  logic accept, hit, miss, full;
  logic [ukst_pkg::IdxW-1:0] last_idx;

  assign busy     = (state_q != ukst_pkg::StIdle);
  assign accept   = start && !busy;
  assign hit      = pend_q && (ram_rdata == key_q);
  assign miss     = !hit && (ridx_q == count_q);
  assign full     = (count_q == ukst_pkg::CntW'(ukst_pkg::TableDepth));
  assign last_idx = ukst_pkg::IdxW'(count_q - 1'b1);

  ukst_ram #(
    .Width(ukst_pkg::KeyW),
    .Depth(ukst_pkg::TableDepth)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ukst_pkg::StIdle: begin
        if (accept) begin
          if (req_i.command == ukst_pkg::CmdPop) begin
            if (count_q != '0) begin
              state_d = ukst_pkg::StPop;
            end
          end else begin
            state_d = ukst_pkg::StSearch;
          end
        end
      end
      ukst_pkg::StSearch: begin
        if (hit && (cmd_q == ukst_pkg::CmdErase)) begin
          state_d = ukst_pkg::StMove;
        end else if (hit || miss) begin
          state_d = ukst_pkg::StIdle;
        end
      end
      ukst_pkg::StMove: state_d = ukst_pkg::StIdle;
      ukst_pkg::StPop:  state_d = ukst_pkg::StIdle;
      default:          state_d = ukst_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_d     = cmd_q;
    key_d     = key_q;
    count_d   = count_q;
    ridx_d    = ridx_q;
    cidx_d    = cidx_q;
    pend_d    = pend_q;
    valid_d   = 1'b0;
    res_d     = '0;
    ram_we    = 1'b0;
    ram_waddr = cidx_q;
    ram_wdata = ram_rdata;
    ram_raddr = ukst_pkg::IdxW'(ridx_q);
    unique case (state_q)
      ukst_pkg::StIdle: begin
        if (accept) begin
          cmd_d     = req_i.command;
          key_d     = req_i.key;
          ridx_d    = '0;
          pend_d    = 1'b0;
          ram_raddr = last_idx;
          if ((req_i.command == ukst_pkg::CmdPop) && (count_q == '0)) begin
            valid_d = 1'b1;
          end
        end
      end
      ukst_pkg::StSearch: begin
        if (hit) begin
          unique case (cmd_q)
            ukst_pkg::CmdAdd: begin
              valid_d    = 1'b1;
              res_d.found = 1'b1;
              res_d.slot  = ukst_pkg::SlotW'(cidx_q);
            end
            ukst_pkg::CmdErase: begin
              ram_raddr = last_idx;
            end
            ukst_pkg::CmdLookup: begin
              valid_d     = 1'b1;
              res_d.found = 1'b1;
            end
            ukst_pkg::CmdPop: begin
              valid_d = 1'b1;
            end
            default: valid_d = 1'b1;
          endcase
        end else if (miss) begin
          valid_d = 1'b1;
          if (cmd_q == ukst_pkg::CmdAdd) begin
            if (full) begin
              res_d.overflow = 1'b1;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = ukst_pkg::IdxW'(count_q);
              ram_wdata  = key_q;
              res_d.slot = ukst_pkg::SlotW'(count_q);
              count_d    = count_q + 1'b1;
            end
          end
        end else begin
          ram_raddr = ukst_pkg::IdxW'(ridx_q);
          pend_d    = 1'b1;
          cidx_d    = ukst_pkg::IdxW'(ridx_q);
          ridx_d    = ridx_q + 1'b1;
        end
      end
      ukst_pkg::StMove: begin
        ram_we      = 1'b1;
        ram_waddr   = cidx_q;
        ram_wdata   = ram_rdata;
        count_d     = count_q - 1'b1;
        valid_d     = 1'b1;
        res_d.found = 1'b1;
      end
      ukst_pkg::StPop: begin
        count_d          = count_q - 1'b1;
        valid_d          = 1'b1;
        res_d.found      = 1'b1;
        res_d.popped_key = ram_rdata;
      end
      default: begin
        valid_d = 1'b0;
      end
    endcase
    res_d.entries = ukst_pkg::EntriesW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ukst_pkg::StIdle;
      count_q <= '0;
      ridx_q  <= '0;
      cidx_q  <= '0;
      pend_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ridx_q  <= ridx_d;
      cidx_q  <= cidx_d;
      pend_q  <= pend_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    key_q <= key_d;
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign rsp_o   = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ukst_pkg::CntW'(ukst_pkg::TableDepth))
    else $error("entry count above table depth");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || valid_o))
    else $error("accepted transfer neither busy nor answered");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.overflow) |->
      (rsp_o.entries == ukst_pkg::EntriesW'(ukst_pkg::TableDepth)))
    else $error("overflow reported on a table that is not full");

  a_move_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ukst_pkg::StMove || state_q == ukst_pkg::StPop) |-> (count_q != '0))
    else $error("remove on an empty table");

endmodule

// ===== src/ukst_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ukst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unordered key set table testbench
// Sends add, erase, pop and lookup commands over the start/busy handshake.
// A shadow copy of the key set computes each expected result. Every strobed
// result is checked field by field against the oldest pending expectation.
// Directed cases cover the empty and full table, swap-remove and the key
// extremes. Random command bursts then grow, shrink and churn the set.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = ukst_pkg::TableDepth + 12;
  localparam int unsigned PoolSize    = 24;
  localparam int unsigned BurstLen    = 40;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic valid_o;
  ukst_pkg::req_t req_i;
  ukst_pkg::rsp_t rsp_o;

  logic [ukst_pkg::KeyW-1:0] shadow_keys [ukst_pkg::TableDepth];
  int unsigned               shadow_count;
  logic [ukst_pkg::KeyW-1:0] key_pool [PoolSize];
  ukst_pkg::rsp_t            set_result_q [$];
  ukst_pkg::rsp_t            oldest_rsp;
  int unsigned               send_idle_pct;
  int unsigned               error_count = 0;
  int unsigned               cycle_count = 0;

  unordered_key_set_table_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic ukst_pkg::rsp_t apply_set_command(ukst_pkg::req_t r);
    ukst_pkg::rsp_t res;
    int   hit;
    int   i;
    res = '0;
    hit = -1;
    for (i = 0; i < int'(shadow_count); i++) begin
      if (hit < 0 && shadow_keys[i] == r.key) begin
        hit = i;
      end
    end
    case (r.command)
      ukst_pkg::CmdAdd: begin
        if (hit >= 0) begin
          res.slot  = ukst_pkg::SlotW'(hit);
          res.found = 1'b1;
        end else if (shadow_count >= ukst_pkg::TableDepth) begin
          res.overflow = 1'b1;
        end else begin
          shadow_keys[shadow_count] = r.key;
          res.slot = ukst_pkg::SlotW'(shadow_count);
          shadow_count++;
        end
      end
      ukst_pkg::CmdErase: begin
        if (hit >= 0) begin
          shadow_count--;
          shadow_keys[hit] = shadow_keys[shadow_count];
          res.found = 1'b1;
        end
      end
      ukst_pkg::CmdPop: begin
        if (shadow_count > 0) begin
          shadow_count--;
          res.popped_key = shadow_keys[shadow_count];
          res.found      = 1'b1;
        end
      end
      default: begin
        res.found = (hit >= 0);
      end
    endcase
    res.entries = ukst_pkg::EntriesW'(shadow_count);
    return res;
  endfunction

  task automatic send_req(ukst_pkg::cmd_e cmd, logic [ukst_pkg::KeyW-1:0] key);
    ukst_pkg::req_t r;
    r.command = cmd;
    r.key     = key;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    req_i = r;
    do @(posedge clk_i); while (busy);
    set_result_q.push_back(apply_set_command(r));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (set_result_q.size() == 0) begin
        $error("unexpected result: no transfer pending");
        error_count++;
      end else begin
        oldest_rsp = set_result_q.pop_front();
        if (rsp_o.slot !== oldest_rsp.slot) begin
          $error("slot mismatch: expected %0d, actual %0d", oldest_rsp.slot, rsp_o.slot);
          error_count++;
        end
        if (rsp_o.found !== oldest_rsp.found) begin
          $error("found mismatch: expected %0b, actual %0b", oldest_rsp.found, rsp_o.found);
          error_count++;
        end
        if (rsp_o.overflow !== oldest_rsp.overflow) begin
          $error("overflow mismatch: expected %0b, actual %0b",
                 oldest_rsp.overflow, rsp_o.overflow);
          error_count++;
        end
        if (rsp_o.popped_key !== oldest_rsp.popped_key) begin
          $error("popped_key mismatch: expected %h, actual %h",
                 oldest_rsp.popped_key, rsp_o.popped_key);
          error_count++;
        end
        if (rsp_o.entries !== oldest_rsp.entries) begin
          $error("entries mismatch: expected %0d, actual %0d",
                 oldest_rsp.entries, rsp_o.entries);
          error_count++;
        end
      end
    end
  end

  task automatic test_empty_table();
    send_req(ukst_pkg::CmdPop, '1);
    send_req(ukst_pkg::CmdLookup, '0);
    send_req(ukst_pkg::CmdErase, '0);
  endtask

  task automatic test_fill_and_overflow();
    int i;
    send_req(ukst_pkg::CmdAdd, '0);
    send_req(ukst_pkg::CmdAdd, '1);
    for (i = 0; i < int'(ukst_pkg::TableDepth) - 2; i++) begin
      send_req(ukst_pkg::CmdAdd, 32'h9E37_79B9 * (i + 1));
    end
    send_req(ukst_pkg::CmdAdd, 32'h5555_5555);
    send_req(ukst_pkg::CmdAdd, '1);
  endtask

  task automatic test_erase_and_pop();
    send_req(ukst_pkg::CmdErase, 32'h9E37_79B9 * 2);
    send_req(ukst_pkg::CmdErase, 32'h5555_5555);
    send_req(ukst_pkg::CmdLookup, '1);
    send_req(ukst_pkg::CmdPop, '0);
  endtask

  function automatic ukst_pkg::cmd_e pick_command(int unsigned mode);
    int unsigned roll;
    int unsigned add_pct;
    int unsigned erase_pct;
    int unsigned pop_pct;
    roll = $urandom_range(99);
    case (mode)
      0: begin
        add_pct   = 60;
        erase_pct = 70;
        pop_pct   = 80;
      end
      1: begin
        add_pct   = 15;
        erase_pct = 50;
        pop_pct   = 80;
      end
      default: begin
        add_pct   = 35;
        erase_pct = 60;
        pop_pct   = 70;
      end
    endcase
    if (roll < add_pct) return ukst_pkg::CmdAdd;
    if (roll < erase_pct) return ukst_pkg::CmdErase;
    if (roll < pop_pct) return ukst_pkg::CmdPop;
    return ukst_pkg::CmdLookup;
  endfunction

  function automatic logic [ukst_pkg::KeyW-1:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) begin
      return key_pool[$urandom_range(PoolSize - 1)];
    end else if (roll < 80 && shadow_count > 0) begin
      return shadow_keys[$urandom_range(shadow_count - 1)];
    end
    return $urandom;
  endfunction

  task automatic test_random_traffic(int unsigned num_items, int unsigned idle_pct);
    int unsigned n;
    int unsigned mode;
    send_idle_pct = idle_pct;
    mode = 0;
    for (n = 0; n < num_items; n++) begin
      if (n % BurstLen == 0) begin
        mode = $urandom_range(2);
        key_pool[$urandom_range(PoolSize - 1)] = $urandom;
      end
      send_req(pick_command(mode), pick_key());
    end
    send_idle_pct = 0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    req_i         = '0;
    shadow_count  = 0;
    send_idle_pct = 0;
    foreach (key_pool[k]) key_pool[k] = $urandom;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_table();
    test_fill_and_overflow();
    test_erase_and_pop();
    test_random_traffic(650, 10);
    test_random_traffic(650, 79);
    test_random_traffic(650, 0);

    @(negedge clk_i);
    start = 1'b0;
    while (set_result_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ukst_pkg.sv
src/ukst_ram.sv
src/unordered_key_set_table_top.sv
tb/tb_top.sv
